/* hw/rtl/lsd_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the LZSS decoder.
package lsd_pkg;

  localparam int unsigned WIN_DEPTH = 4096;              // history size, power of two
  localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);
  localparam int unsigned MAX_RUN   = 18;
  localparam int unsigned CNT_W     = $clog2(MAX_RUN);
  localparam int unsigned LEN_BIAS  = 3;
  localparam logic [7:0]  FILL_BYTE = 8'h20;              // space
  localparam logic [3:0]  GROUP_LEN = 4'd8;               // tokens per flag byte

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_CODE2 = 2'd2
  } phase_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;   // write one fill byte, advance write pointer
    logic take;       // input byte accepted this cycle
    logic rd_issue;   // read history at offset + count
    logic rd_load;    // registered read data into output and copy buffer
    logic wr_step;    // append one copy buffer byte
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last; // final entry of the clearing pass
    logic code2;      // parser waits for the second code byte
    logic cnt_last;   // count has reached the copy length minus one
    logic out_free;   // output register empty or draining this cycle
  } sts_t;

endpackage

/* hw/rtl/lsd_ctrl.sv */
// Controller state machine: clearing pass, byte intake, copy read and append sequencing.
module lsd_ctrl
  import lsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_LOAD  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.take = 1'b1;
          if (sts.code2) state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.rd_load = 1'b1;
        state_nxt   = sts.cnt_last ? S_WRITE : S_READ;
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

/* hw/rtl/lsd_datapath.sv */
// Datapath: history memory, parser registers, copy buffer and output register.
module lsd_datapath
  import lsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_tdata,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [7:0] mem [WIN_DEPTH];
  logic [7:0] rdata_r;
  logic [7:0] copy_buf_r [MAX_RUN];

  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [WIN_AW-1:0] offset_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  len_m1_r;
  logic [7:0]        flag_shift_r, flag_shift_nxt;
  logic [3:0]        consumed_r, consumed_nxt;
  phase_t            phase_r, phase_nxt;
  logic [7:0]        off_hi_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_last_r;

  logic              literal;
  logic              finish;
  logic [3:0]        consumed_inc;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [WIN_AW-1:0] rd_addr;
  logic [11:0]       offset_full;

  assign literal      = cmd.take && (phase_r == PH_TOKEN) && flag_shift_r[0];
  assign finish       = literal || (cmd.wr_step && sts.cnt_last);
  assign consumed_inc = consumed_r + 4'd1;
  assign offset_full  = {off_hi_r, in_tdata[7:4]};
  assign rd_addr      = offset_r + WIN_AW'(cnt_r);

  assign sts.clear_last = (wp_r == WIN_AW'(WIN_DEPTH - 1));
  assign sts.code2      = (phase_r == PH_CODE2);
  assign sts.cnt_last   = (cnt_r == len_m1_r);
  assign sts.out_free   = !out_valid_r || out_tready;

  // single write port: fill, literal or appended copy byte, always at the write pointer
  always_comb begin
    mem_we    = cmd.clr_step || literal || cmd.wr_step;
    mem_wdata = FILL_BYTE;
    if (literal)     mem_wdata = in_tdata;
    if (cmd.wr_step) mem_wdata = copy_buf_r[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wp_r] <= mem_wdata;
    if (cmd.rd_issue) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load) copy_buf_r[cnt_r] <= rdata_r;
  end

  // parser and pointers
  always_comb begin
    wp_nxt         = wp_r;
    cnt_nxt        = cnt_r;
    flag_shift_nxt = flag_shift_r;
    consumed_nxt   = consumed_r;
    phase_nxt      = phase_r;
    if (mem_we) wp_nxt = wp_r + 1'b1;
    if (cmd.rd_load || cmd.wr_step) cnt_nxt = sts.cnt_last ? '0 : cnt_r + 1'b1;
    if (cmd.take) begin
      case (phase_r)
        PH_TOKEN: if (!flag_shift_r[0]) phase_nxt = PH_CODE2;
        PH_CODE2: cnt_nxt = '0;
        default: begin
          flag_shift_nxt = in_tdata;
          consumed_nxt   = '0;
          phase_nxt      = PH_TOKEN;
        end
      endcase
    end
    if (finish) begin
      flag_shift_nxt = flag_shift_r >> 1;
      consumed_nxt   = consumed_inc;
      phase_nxt      = (consumed_inc >= GROUP_LEN) ? PH_FLAG : PH_TOKEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      cnt_r        <= '0;
      len_m1_r     <= '0;
      flag_shift_r <= '0;
      consumed_r   <= '0;
      phase_r      <= PH_FLAG;
    end else begin
      wp_r         <= wp_nxt;
      cnt_r        <= cnt_nxt;
      flag_shift_r <= flag_shift_nxt;
      consumed_r   <= consumed_nxt;
      phase_r      <= phase_nxt;
      if (cmd.take && phase_r == PH_CODE2)
        len_m1_r <= CNT_W'(in_tdata[3:0]) + CNT_W'(LEN_BIAS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && phase_r == PH_TOKEN && !flag_shift_r[0]) off_hi_r <= in_tdata;
    if (cmd.take && phase_r == PH_CODE2) offset_r <= offset_full[WIN_AW-1:0];
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (literal || cmd.rd_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (literal) begin
      out_byte_r <= in_tdata;
      out_last_r <= 1'b1;
    end else if (cmd.rd_load) begin
      out_byte_r <= rdata_r;
      out_last_r <= sts.cnt_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_load |-> !out_valid_r)
    else $error("copy byte loaded over a pending result");

  a_literal_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    literal |-> (!out_valid_r || out_tready))
    else $error("literal taken while output register blocked");

  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    consumed_r <= GROUP_LEN)
    else $error("token count past flag group");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= len_m1_r)
    else $error("copy count past run length");

  a_copy_in_code2: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_issue || cmd.wr_step) |-> (phase_r == PH_CODE2))
    else $error("copy activity outside a code token");
`endif

endmodule

/* hw/rtl/lzss_stream_decoder.sv */
// Top level of the LZSS stream decoder: controller plus datapath.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata[7:0] = compressed byte
//  out_    | out | out_tvalid/out_tready| out_tdata[7:0] = decoded byte,
//          |     |                      | out_tlast = final byte of this token
//
//  After reset a clearing pass fills the 4096-byte history with spaces
//  while in_tready is low.
//  Flag, first code and literal bytes are taken in S_IDLE without leaving it.
//  Second code byte with a copy of L bytes (3..18): intake, then per byte a memory
//  read (S_READ) and an output register load (S_LOAD), then L appends (S_WRITE).
//  The single history port and the one-deep output register set this order;
//  out_tready low holds copy reads and input intake.
module lzss_stream_decoder
  import lsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  cmd_t cmd;
  sts_t sts;

  lsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
